@@ rtl/pfa_pkg.sv @@
// Shared types and constants of the physical frame allocator.
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

    // Item commands
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    // Result status codes
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_NOMEM    = 3'd1;
    localparam logic [2:0] STATUS_REJECT   = 3'd2;
    localparam logic [2:0] STATUS_DISCARD  = 3'd3;
    localparam logic [2:0] STATUS_MAP_FULL = 3'd4;

    // Address map constants
    localparam logic [31:0] USABLE_TYPE = 32'd7;
    localparam logic [51:0] FRAME_BYTES = 52'd4096;
    localparam logic [51:0] LOW_RESERVE = 52'h0_0000_0010_0000;
    localparam logic [52:0] ADDR_LIMIT  = 53'h10_0000_0000_0000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] region_type;
        logic [51:0] region_base;
        logic [39:0] region_pages;
        logic [51:0] free_address;
    } in_t;

    typedef struct packed {
        logic [51:0] frame_address;
        logic [2:0]  status;
        logic [40:0] pages_in_use;
    } out_t;

    typedef struct packed {
        logic [51:0] start;
        logic [39:0] pages;
        logic        usable;
    } map_entry_t;

endpackage

`default_nettype wire

@@ rtl/pfa_map_table.sv @@
// Descriptor table: append-only memory of memory-map entries with a fill count.
`timescale 1ns / 1ps
`default_nettype none

module pfa_map_table
    import pfa_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire map_entry_t load_entry,
    input  wire logic       rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output map_entry_t      rd_entry,
    output logic [CW-1:0]   count,
    output logic            full
);

    map_entry_t    mem [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    map_entry_t    rd_entry_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign count = count_reg;
    assign rd_entry = rd_entry_reg;

    // Advance the fill count on each append
    always_comb begin
        count_next = count_reg;
        if (load && !full) begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Write at the fill point, read through a registered port
    always_ff @(posedge aclk) begin
        if (load && !full) begin
            mem[count_reg[AW-1:0]] <= load_entry;
        end
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/pfa_free_stack.sv @@
// Stack of returned frames held in a memory with a registered pop port.
`timescale 1ns / 1ps
`default_nettype none

module pfa_free_stack
    import pfa_pkg::*;
#(
    parameter int DEPTH = 64,
    localparam int CW = $clog2(DEPTH + 1),
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire logic [51:0] push_data,
    input  wire logic        pop,
    output logic [51:0]      pop_data,
    output logic             empty,
    output logic             full
);

    logic [51:0]   mem [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] top_index;
    logic [51:0]   pop_data_reg;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign top_index = count_reg - CW'(1);
    assign pop_data  = pop_data_reg;

    // Move the stack pointer
    always_comb begin
        count_next = count_reg;
        if (push && !full) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !empty) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Push writes above the top, pop reads the top entry
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem[count_reg[AW-1:0]] <= push_data;
        end
        if (pop && !empty) begin
            pop_data_reg <= mem[top_index[AW-1:0]];
        end
    end

    // Controller never overruns or underruns the stack
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push while stack full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop while stack empty");

endmodule

`default_nettype wire

@@ rtl/physical_frame_allocator.sv @@
// Top level: allocator control, bump region walker and result register.
//
//  Channel | Ports                        | Beat
//  --------+------------------------------+-----------------------------------
//  input   | s_valid, s_ready, s_data     | one command (load, allocate, free)
//  result  | m_valid, m_ready, m_data     | one result per command
//
// Load, free and bump allocations go from idle to finish, a stack pop through a
// pop state. An allocate that must switch regions reads one descriptor per visit
// of the table memory: read and evaluate per entry dropped on type, size or the
// 1 MiB floor, plus fit per entry checked for a whole page; one more read when dry.
// Reset is synchronous and active low; the memories need no clearing pass.
// One item is in flight at a time; a held result stalls the next one.
`timescale 1ns / 1ps
`default_nettype none

module physical_frame_allocator
    import pfa_pkg::*;
#(
    parameter int MAP_DEPTH  = 64,
    parameter int FREE_DEPTH = 64
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    localparam int MAP_CW = $clog2(MAP_DEPTH + 1);
    localparam int MAP_AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_POP       = 3'd1;
    localparam logic [2:0] ST_WALK_RD   = 3'd2;
    localparam logic [2:0] ST_WALK_EVAL = 3'd3;
    localparam logic [2:0] ST_WALK_FIT  = 3'd4;
    localparam logic [2:0] ST_FIN       = 3'd5;

    typedef struct packed {
        logic [51:0] frame_address;
        logic [2:0]  status;
    } res_t;

    function automatic logic [40:0] count_up(input logic [40:0] c);
        return (c == '1) ? c : c + 41'd1;
    endfunction

    function automatic logic [40:0] count_down(input logic [40:0] c);
        return (c == '0) ? c : c - 41'd1;
    endfunction

    logic [2:0]        state_reg, state_next;
    res_t              res_reg, res_next;
    logic [40:0]       in_use_reg, in_use_next;
    logic [51:0]       bump_reg, bump_next;
    logic [39:0]       left_reg, left_next;
    logic [MAP_CW-1:0] walk_index_reg, walk_index_next;
    logic [52:0]       hi_reg, hi_next;
    logic [51:0]       lo_reg, lo_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg, m_data_next;

    logic              map_load;
    map_entry_t        map_load_entry;
    logic              map_rd_en;
    map_entry_t        map_rd_entry;
    logic [MAP_CW-1:0] map_count;
    logic              map_full;

    logic              stack_push;
    logic              stack_pop;
    logic [51:0]       stack_pop_data;
    logic              stack_empty;
    logic              stack_full;

    logic [52:0]       walk_sum;
    logic [52:0]       hi_clip;
    logic [52:0]       fit_diff;
    logic [39:0]       fit_pages;

    pfa_map_table #(.DEPTH(MAP_DEPTH)) u_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (map_load),
        .load_entry (map_load_entry),
        .rd_en      (map_rd_en),
        .rd_addr    (walk_index_reg[MAP_AW-1:0]),
        .rd_entry   (map_rd_entry),
        .count      (map_count),
        .full       (map_full)
    );

    pfa_free_stack #(.DEPTH(FREE_DEPTH)) u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (stack_push),
        .push_data (s_data.free_address),
        .pop       (stack_pop),
        .pop_data  (stack_pop_data),
        .empty     (stack_empty),
        .full      (stack_full)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Build the descriptor entry from the load beat
    always_comb begin
        map_load_entry.start  = s_data.region_base;
        map_load_entry.pages  = s_data.region_pages;
        map_load_entry.usable = (s_data.region_type == USABLE_TYPE);
    end

    // Region bounds: end address clipped to the address space, size in frames
    assign walk_sum  = {1'b0, map_rd_entry.start} + {1'b0, map_rd_entry.pages, 12'd0};
    assign hi_clip   = walk_sum[52] ? ADDR_LIMIT : walk_sum;
    assign fit_diff  = hi_reg - {1'b0, lo_reg};
    assign fit_pages = fit_diff[51:12];

    // Allocator control
    always_comb begin
        state_next      = state_reg;
        res_next        = res_reg;
        in_use_next     = in_use_reg;
        bump_next       = bump_reg;
        left_next       = left_reg;
        walk_index_next = walk_index_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        map_load        = 1'b0;
        map_rd_en       = 1'b0;
        stack_push      = 1'b0;
        stack_pop       = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    res_next.frame_address = '0;
                    res_next.status        = STATUS_OK;
                    state_next             = ST_FIN;
                    unique case (s_data.cmd)
                        CMD_LOAD: begin
                            if (map_full) begin
                                res_next.status = STATUS_MAP_FULL;
                            end else begin
                                map_load = 1'b1;
                            end
                        end
                        CMD_ALLOC: begin
                            if (!stack_empty) begin
                                stack_pop  = 1'b1;
                                state_next = ST_POP;
                            end else if (left_reg != '0) begin
                                res_next.frame_address = bump_reg;
                                bump_next   = bump_reg + FRAME_BYTES;
                                left_next   = left_reg - 40'd1;
                                in_use_next = count_up(in_use_reg);
                            end else begin
                                state_next = ST_WALK_RD;
                            end
                        end
                        CMD_FREE: begin
                            if (s_data.free_address == '0 ||
                                s_data.free_address[11:0] != '0) begin
                                res_next.status = STATUS_REJECT;
                            end else if (stack_full) begin
                                res_next.status = STATUS_DISCARD;
                            end else begin
                                stack_push  = 1'b1;
                                in_use_next = count_down(in_use_reg);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_POP: begin
                res_next.frame_address = stack_pop_data;
                in_use_next            = count_up(in_use_reg);
                state_next             = ST_FIN;
            end
            ST_WALK_RD: begin
                // Read the next descriptor, or give up when the table is spent
                if (walk_index_reg < map_count) begin
                    map_rd_en       = 1'b1;
                    walk_index_next = walk_index_reg + MAP_CW'(1);
                    state_next      = ST_WALK_EVAL;
                end else begin
                    res_next.status = STATUS_NOMEM;
                    state_next      = ST_FIN;
                end
            end
            ST_WALK_EVAL: begin
                // Drop unusable, empty and low-memory-only regions
                hi_next = hi_clip;
                lo_next = (map_rd_entry.start < LOW_RESERVE) ? LOW_RESERVE
                                                             : map_rd_entry.start;
                if (!map_rd_entry.usable || map_rd_entry.pages == '0 ||
                    hi_clip <= {1'b0, LOW_RESERVE}) begin
                    state_next = ST_WALK_RD;
                end else begin
                    state_next = ST_WALK_FIT;
                end
            end
            ST_WALK_FIT: begin
                // Take the first frame of the region if it holds a whole page
                if (hi_reg <= {1'b0, lo_reg} || fit_pages == '0) begin
                    state_next = ST_WALK_RD;
                end else begin
                    res_next.frame_address = lo_reg;
                    bump_next   = lo_reg + FRAME_BYTES;
                    left_next   = fit_pages - 40'd1;
                    in_use_next = count_up(in_use_reg);
                    state_next  = ST_FIN;
                end
            end
            ST_FIN: begin
                // Hand the result to the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.frame_address  = res_reg.frame_address;
                    m_data_next.status         = res_reg.status;
                    m_data_next.pages_in_use   = in_use_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            in_use_reg     <= '0;
            bump_reg       <= '0;
            left_reg       <= '0;
            walk_index_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            in_use_reg     <= in_use_next;
            bump_reg       <= bump_next;
            left_reg       <= left_next;
            walk_index_reg <= walk_index_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        m_data_reg <= m_data_next;
    end

    a_walk_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_index_reg <= map_count)
        else $error("walk index past descriptor count");
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat accepted while busy");
    a_nomem_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == STATUS_NOMEM) |-> (m_data.frame_address == '0))
        else $error("out-of-memory result carries a frame");
    a_fit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK_FIT) |-> (hi_reg > {1'b0, LOW_RESERVE}))
        else $error("fit check on a region below the low reserve");

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the physical frame allocator.
`timescale 1ns / 1ps

module tb_top;
    import pfa_pkg::*;

    localparam int MAP_DEPTH  = 64;
    localparam int FREE_DEPTH = 64;
    // Command code that the block must ignore
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic m_ready = 1'b0;
    in_t  s_data  = '0;
    logic s_ready;
    logic m_valid;
    out_t m_data;

    physical_frame_allocator #(
        .MAP_DEPTH (MAP_DEPTH),
        .FREE_DEPTH(FREE_DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #4 aclk = ~aclk;

    // Allocator state as the bench sees it
    logic [51:0] desc_start [MAP_DEPTH];
    logic [39:0] desc_pages [MAP_DEPTH];
    bit          desc_usable[MAP_DEPTH];
    int          map_count   = 0;
    int          walk_index  = 0;
    logic [51:0] bump_address = '0;
    logic [39:0] region_left  = '0;
    logic [51:0] returned_frames[FREE_DEPTH];
    int          stack_count = 0;
    logic [40:0] in_use      = '0;

    out_t        expected_results[$];
    logic [51:0] handed_out[$];

    bit no_idle      = 1'b0;
    int hold_request = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int status_count[8];

    // Walk the table for the next usable region; true when one was found
    function automatic bit take_next_region();
        int i;
        bit found;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] span;
        found = 1'b0;
        while (walk_index < map_count && !found) begin
            i = walk_index;
            walk_index++;
            if (desc_usable[i] && desc_pages[i] != '0) begin
                lo = {12'd0, desc_start[i]};
                hi = lo + {12'd0, desc_pages[i], 12'd0};
                if (hi > {11'd0, ADDR_LIMIT}) hi = {11'd0, ADDR_LIMIT};
                if (hi > {12'd0, LOW_RESERVE}) begin
                    if (lo < {12'd0, LOW_RESERVE}) lo = {12'd0, LOW_RESERVE};
                    span = hi - lo;
                    if (hi > lo && span[63:12] != '0) begin
                        found        = 1'b1;
                        bump_address = lo[51:0];
                        region_left  = span[51:12];
                    end
                end
            end
        end
        return found;
    endfunction

    // Compute the result of one accepted beat and advance the state
    function automatic out_t predict_result(in_t item);
        out_t r;
        bit   got;
        r = '0;
        r.status = STATUS_OK;
        got = 1'b0;
        case (item.cmd)
            CMD_LOAD: begin
                if (map_count < MAP_DEPTH) begin
                    desc_start[map_count]  = item.region_base;
                    desc_pages[map_count]  = item.region_pages;
                    desc_usable[map_count] = (item.region_type == USABLE_TYPE);
                    map_count++;
                end else begin
                    r.status = STATUS_MAP_FULL;
                end
            end
            CMD_ALLOC: begin
                if (stack_count > 0) begin
                    stack_count--;
                    r.frame_address = returned_frames[stack_count];
                    got = 1'b1;
                end else if (region_left != '0 || take_next_region()) begin
                    r.frame_address = bump_address;
                    bump_address    = bump_address + FRAME_BYTES;
                    region_left     = region_left - 40'd1;
                    got = 1'b1;
                end else begin
                    r.status = STATUS_NOMEM;
                end
                if (got) begin
                    if (in_use != '1) in_use = in_use + 41'd1;
                    handed_out.push_back(r.frame_address);
                    if (handed_out.size() > 128) void'(handed_out.pop_front());
                end
            end
            CMD_FREE: begin
                if (item.free_address == '0 || item.free_address[11:0] != '0) begin
                    r.status = STATUS_REJECT;
                end else if (stack_count < FREE_DEPTH) begin
                    returned_frames[stack_count] = item.free_address;
                    stack_count++;
                    if (in_use != '0) in_use = in_use - 41'd1;
                end else begin
                    r.status = STATUS_DISCARD;
                end
            end
            default: ;
        endcase
        r.pages_in_use = in_use;
        return r;
    endfunction

    // Idle length: mostly none, sometimes short, rarely long
    function automatic int idle_cycles();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [51:0] rand_addr();
        logic [63:0] r64;
        r64 = {$urandom(), $urandom()};
        return r64[51:0];
    endfunction

    function automatic logic [51:0] rand_frame();
        logic [51:0] a;
        a = rand_addr();
        a[11:0] = 12'd0;
        if (a == '0) a = FRAME_BYTES;
        return a;
    endfunction

    // Fill every field with noise; callers override what matters
    function automatic in_t random_fill();
        in_t it;
        logic [63:0] r64;
        logic [31:0] u;
        u = $urandom_range(0, 3);
        r64 = {$urandom(), $urandom()};
        it.cmd          = u[1:0];
        it.region_type  = $urandom();
        it.region_base  = rand_addr();
        it.region_pages = r64[39:0];
        it.free_address = rand_addr();
        return it;
    endfunction

    // Offer one beat, hold it until accepted, then record its expected result
    task automatic send_item(input in_t item);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(predict_result(item));
        items_sent++;
    endtask

    task automatic send_alloc();
        in_t it;
        it = random_fill();
        it.cmd = CMD_ALLOC;
        send_item(it);
    endtask

    task automatic send_free(input logic [51:0] addr);
        in_t it;
        it = random_fill();
        it.cmd = CMD_FREE;
        it.free_address = addr;
        send_item(it);
    endtask

    task automatic send_load(input logic [31:0] kind, input logic [51:0] start,
                             input logic [39:0] pages);
        in_t it;
        it = random_fill();
        it.cmd          = CMD_LOAD;
        it.region_type  = kind;
        it.region_base  = start;
        it.region_pages = pages;
        send_item(it);
    endtask

    task automatic send_unknown();
        in_t it;
        it = random_fill();
        it.cmd = CMD_UNKNOWN;
        send_item(it);
    endtask

    // Mostly small usable regions, some near 1 MiB or unaligned, the rest noise
    task automatic send_random_load();
        in_t it;
        logic [31:0] u;
        int r;
        it = random_fill();
        it.cmd = CMD_LOAD;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            it.region_type = USABLE_TYPE;
            u = $urandom_range(1, 6);
            it.region_pages = {8'd0, u};
            if (r < 12) begin
                u = $urandom_range(0, 'h1FF);
                it.region_base = {20'd0, u[19:0], 12'd0};
            end else if (r >= 20) begin
                it.region_base[11:0] = 12'd0;
            end
        end
        send_item(it);
    endtask

    // Return frames handed out earlier, fresh frames, and bad addresses
    task automatic send_random_free();
        logic [51:0] addr;
        logic [31:0] u;
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            addr = '0;
        end else if (r < 18) begin
            addr = rand_addr();
            u = $urandom_range(1, 4095);
            addr[11:0] = u[11:0];
        end else if (r < 60 && handed_out.size() != 0) begin
            k = $urandom_range(0, handed_out.size() - 1);
            addr = handed_out[k];
            handed_out.delete(k);
        end else begin
            addr = rand_frame();
        end
        send_free(addr);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        // Nothing loaded and nothing returned yet
        send_alloc();
        // Reject null and unaligned frees, then return a frame with nothing in use
        send_free('0);
        send_free(52'h0_0000_0000_1001);
        send_free(52'h0_0000_0000_5000);
        send_alloc();
        send_unknown();
        // Regions the walk must skip or clip
        send_load(32'd1, 52'h20_0000, 40'd100);
        send_load(USABLE_TYPE, 52'h30_0000, 40'd0);
        send_load(USABLE_TYPE, 52'h0, 40'h100);
        send_load(USABLE_TYPE, 52'hF_F800, 40'd1);
        send_load(USABLE_TYPE, 52'h8_0000, 40'h81);
        send_load(USABLE_TYPE, 52'h20_0800, 40'd2);
        send_load(USABLE_TYPE, 52'hF_FFFF_FFFF_E000, '1);
        send_load(32'hFFFF_FFFF, '1, '1);
        // Use up every usable page, then run dry
        repeat (6) send_alloc();
        // A descriptor loaded after the walk ran out is picked up
        send_load(USABLE_TYPE, 52'h40_0000, 40'd1);
        send_alloc();
        send_free(52'hF_FFFF_FFFF_F000);
        send_alloc();
    endtask

    task automatic test_random_mix();
        int r;
        for (int n = 0; n < 1000; n++) begin
            if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 6 && map_count < MAP_DEPTH - 8) send_random_load();
            else if (r < 58) send_alloc();
            else if (r < 92) send_random_free();
            else send_unknown();
        end
        no_idle = 1'b0;
    endtask

    // Hold the result side off while beats keep coming
    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_request = 300;
        repeat (6) begin
            send_alloc();
            send_random_free();
        end
        no_idle = 1'b0;
    endtask

    // Fill the free stack, overflow it, then pop a few
    task automatic test_stack_full();
        repeat (FREE_DEPTH - stack_count + 3) send_free(rand_frame());
        repeat (5) send_alloc();
        repeat (2) send_free(rand_frame());
    endtask

    // Fill the descriptor table, overflow it, then drain stack and regions
    task automatic test_map_full();
        repeat (MAP_DEPTH - map_count + 4) send_random_load();
        repeat (stack_count + 30) send_alloc();
    endtask

    // Result side: random stalls plus the long hold-off on request
    initial begin : result_ready
        int stall;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end else if (!no_idle && $urandom_range(0, 3) == 0) begin
                stall = idle_cycles();
            end else begin
                stall = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin : result_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            status_count[m_data.status]++;
            if (expected_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("Unexpected result: frame %h status %0d pages %0d",
                             m_data.frame_address, m_data.status, m_data.pages_in_use);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.frame_address !== want.frame_address ||
                    m_data.status !== want.status ||
                    m_data.pages_in_use !== want.pages_in_use) begin
                    if (mismatch_count < 10)
                        $display({"Mismatch at result %0d: expected frame %h status %0d ",
                                  "pages %0d, got frame %h status %0d pages %0d"},
                                 results_seen, want.frame_address, want.status,
                                 want.pages_in_use, m_data.frame_address, m_data.status,
                                 m_data.pages_in_use);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #25_000_000;
        $display("FAIL physical_frame_allocator");
        $finish;
    end

    initial begin : run
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        wait_drained();
        test_random_mix();
        wait_drained();
        test_backpressure();
        wait_drained();
        test_stack_full();
        wait_drained();
        test_map_full();
        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Covered %0d commands, %0d results, %0d descriptors, %0d frames in use at end",
                 items_sent, results_seen, map_count, in_use);
        $display("Out of memory %0d, frees rejected %0d, discarded %0d, table full %0d, errors %0d",
                 status_count[STATUS_NOMEM], status_count[STATUS_REJECT],
                 status_count[STATUS_DISCARD], status_count[STATUS_MAP_FULL], mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS physical_frame_allocator");
        end else begin
            $display("FAIL physical_frame_allocator");
        end
        $finish;
    end

endmodule
